[design/red_pkg.sv]
package red_pkg;

  // Width of the step counter and of the debounce timer
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned TIMER_BITS = 20;

  // Field widths of the ports
  localparam int unsigned POS_W      = 32;
  localparam int unsigned DEB_W      = 20;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W  = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_DIRECTION = 1'd1;

  // Register reset values
  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(1000);

  typedef enum logic [2:0] {
    PH_ARMED    = 3'b001,
    PH_DEBOUNCE = 3'b010,
    PH_WAIT     = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_e;

  typedef struct packed {
    logic [POS_W-1:0] position;
    dir_e             direction;
    logic             step_event;
  } result_t;

endpackage

[design/rotary_encoder_debounced_decoder_core.sv]
// A result is registered in the output register, or in the skid when it is stalled.
// Throughput: one item per cycle while the skid is empty; the phase machine, debounce
// timer and step counter all update in the cycle the item is taken.
// A two-entry result buffer (output register plus skid) keeps input open while
// a result waits. Reset: asynchronous, active low; pins idle high, phase armed.
module rotary_encoder_debounced_decoder_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                clk_level_i,
  input  logic                                dta_level_i,
  input  logic                                clear_count_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [red_pkg::POS_W-1:0]    position_o,
  output logic [1:0]                          direction_o,
  output logic                                step_event_o,
  // register write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [red_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [red_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  // ---------------- configuration registers ----------------
  logic [red_pkg::DEB_W-1:0] deb_ticks_q;
  logic                      flip_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q <= red_pkg::DEBOUNCE_RESET;
      flip_q      <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        red_pkg::CFG_DEBOUNCE_TICKS: deb_ticks_q <= red_pkg::DEB_W'(cfg_data_i);
        red_pkg::CFG_FLIP_DIRECTION: flip_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- decoder state ----------------
  logic                                last_clk_q, last_clk_d;
  logic                                last_dta_q, last_dta_d;
  red_pkg::phase_e                     phase_q, phase_d;
  logic [red_pkg::TIMER_BITS-1:0]      timer_q, timer_d;
  logic                                cap_dta_q, cap_dta_d;
  logic [red_pkg::COUNT_BITS-1:0]      count_q, count_d;
  red_pkg::dir_e                       dir_q, dir_d;

  // result buffer: output register plus skid entry
  red_pkg::result_t                    out_q, out_d;
  red_pkg::result_t                    skid_q, skid_d;
  logic                                out_valid_q, out_valid_d;
  logic                                skid_valid_q, skid_valid_d;

  logic                                in_xfer;
  logic                                out_xfer;
  logic                                clk_fall;
  logic                                dta_edge;
  logic                                stepped;
  logic [red_pkg::TIMER_BITS-1:0]      timer_dec;
  logic [red_pkg::TIMER_BITS-1:0]      timer_load;
  red_pkg::result_t                    res;

  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i && !skid_valid_q;
  assign out_xfer   = out_valid_q && !out_stall_i;

  assign clk_fall   = last_clk_q && !clk_level_i;
  assign dta_edge   = last_dta_q != dta_level_i;
  assign timer_dec  = timer_q - 1'b1;

  // zero load counts as one tick
  always_comb begin
    timer_load = red_pkg::TIMER_BITS'(deb_ticks_q);
    if (timer_load == '0) begin
      timer_load = red_pkg::TIMER_BITS'(1);
    end
  end

  // one tick of the phase machine
  always_comb begin
    phase_d   = phase_q;
    timer_d   = timer_q;
    cap_dta_d = cap_dta_q;
    count_d   = count_q;
    dir_d     = dir_q;
    stepped   = 1'b0;

    case (phase_q)
      red_pkg::PH_DEBOUNCE: begin
        if (dta_edge) begin
          // data bounce cancels the pending check
          timer_d = '0;
          phase_d = red_pkg::PH_ARMED;
        end else begin
          timer_d = timer_dec;
          if (timer_dec == '0) begin
            if (!clk_level_i && (dta_level_i == cap_dta_q)) begin
              if (cap_dta_q == !flip_q) begin
                count_d = count_q + 1'b1;
                dir_d   = red_pkg::DIR_CW;
              end else begin
                count_d = count_q - 1'b1;
                dir_d   = red_pkg::DIR_CCW;
              end
              stepped = 1'b1;
              phase_d = red_pkg::PH_WAIT;
            end else begin
              phase_d = red_pkg::PH_ARMED;
            end
          end
        end
      end
      red_pkg::PH_WAIT: begin
        if (dta_edge) begin
          phase_d = red_pkg::PH_ARMED;
        end
      end
      default: begin
        if (clk_fall) begin
          cap_dta_d = dta_level_i;
          timer_d   = timer_load;
          phase_d   = red_pkg::PH_DEBOUNCE;
        end else begin
          phase_d = red_pkg::PH_ARMED;
        end
      end
    endcase

    // clear wins over a step on the same tick
    if (clear_count_i) begin
      count_d = '0;
      dir_d   = red_pkg::DIR_NONE;
      stepped = 1'b0;
    end

    last_clk_d = clk_level_i;
    last_dta_d = dta_level_i;
  end

  // count is sign-extended or truncated to the port width
  always_comb begin
    res.position   = red_pkg::POS_W'(signed'(count_d));
    res.direction  = dir_d;
    res.step_event = stepped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_clk_q <= 1'b1;
      last_dta_q <= 1'b1;
      phase_q    <= red_pkg::PH_ARMED;
      timer_q    <= '0;
      cap_dta_q  <= 1'b0;
      count_q    <= '0;
      dir_q      <= red_pkg::DIR_NONE;
    end else if (in_xfer) begin
      last_clk_q <= last_clk_d;
      last_dta_q <= last_dta_d;
      phase_q    <= phase_d;
      timer_q    <= timer_d;
      cap_dta_q  <= cap_dta_d;
      count_q    <= count_d;
      dir_q      <= dir_d;
    end
  end

  // result buffer steering: skid drains first, keeps order
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    out_valid_d  = out_valid_q && !out_xfer;

    if (!out_valid_q || out_xfer) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (in_xfer) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end
    end else if (in_xfer) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o  = out_valid_q;
  assign position_o   = signed'(out_q.position);
  assign direction_o  = out_q.direction;
  assign step_event_o = out_q.step_event;

endmodule

[sim/encoder_step_checker.sv]
module encoder_step_checker
  import red_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        clk_level_i,
  input  logic                        dta_level_i,
  input  logic                        clear_count_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic signed [POS_W-1:0]     position_i,
  input  logic [1:0]                  direction_i,
  input  logic                        step_event_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  // Shadow registers
  logic [DEB_W-1:0]      deb_ticks;
  logic                  flip_dir;

  // Shadow decoder state
  logic                  prev_clk;
  logic                  prev_dta;
  phase_e                enc_phase;
  logic [TIMER_BITS-1:0] settle_timer;
  logic                  held_dta;
  logic [COUNT_BITS-1:0] step_total;
  dir_e                  turn_dir;

  result_t               expected_ticks[$];

  // Advances the shadow decoder by one pin sample and returns the tick's result.
  function automatic result_t decode_sample(logic c, logic d, logic clr);
    result_t               r;
    logic                  stepped;
    logic [TIMER_BITS-1:0] load;
    stepped = 1'b0;
    case (enc_phase)
      PH_DEBOUNCE: begin
        if (prev_dta != d) begin
          settle_timer = '0;
          enc_phase    = PH_ARMED;
        end else begin
          settle_timer = settle_timer - 1'b1;
          if (settle_timer == '0) begin
            if (!c && d == held_dta) begin
              if (held_dta == !flip_dir) begin
                step_total = step_total + 1'b1;
                turn_dir   = DIR_CW;
              end else begin
                step_total = step_total - 1'b1;
                turn_dir   = DIR_CCW;
              end
              stepped   = 1'b1;
              enc_phase = PH_WAIT;
            end else begin
              enc_phase = PH_ARMED;
            end
          end
        end
      end
      PH_WAIT: begin
        if (prev_dta != d) enc_phase = PH_ARMED;
      end
      default: begin
        if (prev_clk && !c) begin
          load = deb_ticks[TIMER_BITS-1:0];
          if (load == '0) load = TIMER_BITS'(1);
          held_dta     = d;
          settle_timer = load;
          enc_phase    = PH_DEBOUNCE;
        end else begin
          enc_phase = PH_ARMED;
        end
      end
    endcase
    if (clr) begin
      step_total = '0;
      turn_dir   = DIR_NONE;
      stepped    = 1'b0;
    end
    prev_clk = c;
    prev_dta = d;
    r.position   = POS_W'(step_total);
    r.direction  = turn_dir;
    r.step_event = stepped;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t want;
    if (!rst_ni) begin
      deb_ticks    = DEBOUNCE_RESET;
      flip_dir     = 1'b0;
      prev_clk     = 1'b1;
      prev_dta     = 1'b1;
      enc_phase    = PH_ARMED;
      settle_timer = '0;
      held_dta     = 1'b0;
      step_total   = '0;
      turn_dir     = DIR_NONE;
      expected_ticks.delete();
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      // compare before predicting: a result never leaves on its own input's edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_ticks.size() == 0) begin
          $error("result transfer with nothing expected: position %0d", position_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = expected_ticks.pop_front();
          if (position_i !== want.position) begin
            $error("position: expected %0d, got %0d", $signed(want.position), position_i);
            fail_count_o = fail_count_o + 1;
          end
          if (direction_i !== want.direction) begin
            $error("direction: expected %0d, got %0d", want.direction, direction_i);
            fail_count_o = fail_count_o + 1;
          end
          if (step_event_i !== want.step_event) begin
            $error("step_event: expected %0d, got %0d", want.step_event, step_event_i);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_DEBOUNCE_TICKS: deb_ticks = cfg_data_i[DEB_W-1:0];
          CFG_FLIP_DIRECTION: flip_dir  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_ticks.push_back(decode_sample(clk_level_i, dta_level_i, clear_count_i));
      pending_o <= expected_ticks.size();
    end
  end

endmodule

[sim/tb_top.sv]
module tb_top;
  import red_pkg::*;

  // Cycles without any transfer on any channel before the run is declared hung.
  // Honest stalls and gaps are much shorter, so this is generous.
  localparam int HANG_LIMIT = 2000;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     clk_level_i;
  logic                     dta_level_i;
  logic                     clear_count_i;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [POS_W-1:0]  position_o;
  logic [1:0]               direction_o;
  logic                     step_event_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [CFG_DATA_W-1:0]    cfg_data_i;

  int fail_count;
  int pending;
  int samples_sent;
  int hung_cycles = 0;

  // Idling knobs: sender gaps and receiver stalls are switched per phase.
  bit sender_gaps;
  bit receiver_stalls;

  rotary_encoder_debounced_decoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .clk_level_i   (clk_level_i),
    .dta_level_i   (dta_level_i),
    .clear_count_i (clear_count_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .position_o    (position_o),
    .direction_o   (direction_o),
    .step_event_o  (step_event_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  encoder_step_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .clk_level_i   (clk_level_i),
    .dta_level_i   (dta_level_i),
    .clear_count_i (clear_count_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .position_i    (position_o),
    .direction_i   (direction_o),
    .step_event_i  (step_event_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: random stall bursts while enabled. Each pass through the loop
  // makes at most one assignment per clock edge.
  always begin
    @(posedge clk_i);
    if (receiver_stalls && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    out_stall_i <= 1'b0;
  end

  // Hang watchdog: any transfer on any channel restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        hung_cycles <= 0;
      end else if (hung_cycles >= HANG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        hung_cycles <= hung_cycles + 1;
      end
    end
  end

  function automatic logic rare_clear();
    return $urandom_range(0, 39) == 0;
  endfunction

  // One pin sample transfer. An optional gap comes first; valid then stays
  // high until the next sample or the next drain lowers it.
  task automatic send_sample(input logic c, input logic d, input logic clr);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    clk_level_i   <= c;
    dta_level_i   <= d;
    clear_count_i <= clr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    samples_sent++;
  endtask

  // Sender holds off until every expected result is back, then lets the
  // output pipe settle before a register write.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes both registers back to back; valid is lowered once at the end.
  task automatic set_config(input logic [DEB_W-1:0] ticks, input logic flip);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_DEBOUNCE_TICKS;
    cfg_data_i  <= CFG_DATA_W'(ticks);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CFG_FLIP_DIRECTION;
    cfg_data_i  <= CFG_DATA_W'(flip);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic scramble(input int n);
    repeat (n) send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rare_clear());
  endtask

  // One detent of a real knob: data settles, clock falls and is held low
  // across the debounce window (sometimes too briefly, sometimes with a data
  // glitch), then the clock rises and data swaps so the decoder re-arms.
  task automatic turn_detent(input logic [DEB_W-1:0] ticks);
    logic d;
    int   low_ticks;
    d = 1'($urandom_range(0, 1));
    low_ticks = (ticks == 0 ? 1 : int'(ticks)) + 1 + $urandom_range(0, 2);
    if ($urandom_range(0, 5) == 0) low_ticks -= 1 + $urandom_range(0, 1);
    repeat ($urandom_range(1, 2)) send_sample(1'b1, d, rare_clear());
    repeat (low_ticks) begin
      send_sample(1'b0, ($urandom_range(0, 19) == 0) ? !d : d, rare_clear());
    end
    repeat ($urandom_range(1, 2)) send_sample(1'b1, !d, rare_clear());
    repeat ($urandom_range(0, 2)) send_sample(1'b1, 1'b1, rare_clear());
  endtask

  // Mostly well-formed detents, with short bursts of pin noise between them.
  task automatic run_turns(input int n_samples, input logic [DEB_W-1:0] ticks);
    int stop_at;
    stop_at = samples_sent + n_samples;
    while (samples_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) scramble($urandom_range(1, 4));
      else turn_detent(ticks);
    end
  endtask

  initial begin
    logic [DEB_W-1:0] ticks;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    clk_level_i     = 1'b1;
    dta_level_i     = 1'b1;
    clear_count_i   = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_DEBOUNCE_TICKS;
    cfg_data_i      = '0;
    samples_sent    = 0;
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: a clock fall loads the long default window and a data
    // edge cancels it.
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0);

    // Shortest window, normal direction.
    set_config(DEB_W'(1), 1'b0);
    send_sample(1'b1, 1'b1, 1'b0);  // data edge while armed is ignored
    send_sample(1'b0, 1'b1, 1'b0);  // fall, data high captured
    send_sample(1'b0, 1'b1, 1'b0);  // clockwise step
    send_sample(1'b1, 1'b1, 1'b0);  // clock edge ignored while waiting
    send_sample(1'b1, 1'b0, 1'b0);  // data edge re-arms
    send_sample(1'b0, 1'b0, 1'b0);  // fall, data low captured
    send_sample(1'b0, 1'b0, 1'b0);  // counter-clockwise step back to zero
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0);  // fall together with a data edge
    send_sample(1'b0, 1'b0, 1'b0);  // step below zero, count wraps negative
    send_sample(1'b1, 1'b1, 1'b1);  // clear while waiting
    send_sample(1'b0, 1'b1, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0);  // data edge on the expiry tick wins
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0);  // clock back high at expiry: rejected
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b1);  // valid step overridden by clear
    send_sample(1'b1, 1'b1, 1'b0);

    // Random part, several settings.
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    set_config(DEB_W'(1), 1'b1);
    run_turns(150, DEB_W'(1));

    // Zero window acts as a single tick.
    set_config('0, 1'b0);
    run_turns(150, '0);

    // Longest window never expires here; only loads and cancels are seen.
    set_config('1, 1'b1);
    scramble(40);

    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    set_config(DEB_W'(2), 1'b0);
    run_turns(150, DEB_W'(2));

    repeat (6) begin
      ticks = DEB_W'($urandom_range(1, 8));
      sender_gaps     = $urandom_range(0, 3) != 0;
      receiver_stalls = $urandom_range(0, 3) != 0;
      set_config(ticks, 1'($urandom_range(0, 1)));
      run_turns(170, ticks);
    end

    // Closing stretch at full rate on both sides.
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    set_config(DEB_W'(3), 1'($urandom_range(0, 1)));
    run_turns(150, DEB_W'(3));

    drain_results();
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
